FILE: rtl/rc3_pkg.sv
// rc3_pkg: shared types, register codes and reset values for the rgba 3x3 filter
// depends on nothing; rc3_line, rc3_mac and the top level refer to it by scoped names
package rc3_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 4096;

  localparam int unsigned PixW   = 32;
  localparam int unsigned KernW  = 24;
  localparam int unsigned ImgWW  = 12;
  localparam int unsigned ImgHW  = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ProdW  = 17;
  localparam int unsigned SumW   = 21;

  localparam logic [ImgWW-1:0] WidthRst  = 12'd640;
  localparam logic [ImgHW-1:0] HeightRst = 13'd480;
  localparam logic [KernW-1:0] KernTopRst = 24'd256;
  localparam logic [KernW-1:0] KernMidRst = 24'd129025;
  localparam logic [KernW-1:0] KernBotRst = 24'd256;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH    = 3'd0,
    CFG_HEIGHT   = 3'd1,
    CFG_KERN_TOP = 3'd2,
    CFG_KERN_MID = 3'd3,
    CFG_KERN_BOT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic       command;
    logic [7:0] alpha_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } pix_out_t;

  typedef logic [2:0][KernW-1:0] kernel_t;

  // one column of the window with the output decisions made for it
  typedef struct packed {
    logic            valid;
    logic [PixW-1:0] older;
    logic [PixW-1:0] newer;
    logic [PixW-1:0] pixel;
    logic [8:0]      mask;
    logic            emit;
    logic            last;
    logic            clear;
  } col_beat_t;

endpackage

FILE: rtl/rc3_ram.sv
// rc3_ram: generic single write, single read ram with registered read data
// no dependencies; a read of the address being written returns the old data
module rc3_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rc3_line.sv
// rc3_line: raster counters, the two row memories and their read-modify-write stage
// depends on rc3_pkg and rc3_ram
module rc3_line #(
  parameter int unsigned MAX_WIDTH  = rc3_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = rc3_pkg::MaxHeightDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       in_valid_i,
  input  rc3_pkg::pix_in_t           in_data_i,
  input  logic [rc3_pkg::ImgWW-1:0]  image_width_i,
  input  logic [rc3_pkg::ImgHW-1:0]  image_height_i,
  output rc3_pkg::col_beat_t         beat_o
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned ColW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT + 4) + 1;
  localparam int unsigned SW   = RowW + 1;

  logic [ColW-1:0] col_q, col_d, w_eff, c0, c1, c1n, ox;
  logic [RowW-1:0] row_q, row_d, h_eff, r0, r1;
  logic            drain_q, drain_d, d0, d1;
  logic [31:0]     w_ext, h_ext;
  logic signed [SW-1:0] oy, h_s;
  logic            accept, take, wrap0, wrap1, neg, past, lastp, emit, clr;
  logic [2:0]      row_ok, col_ok;
  logic [8:0]      mask;
  logic [rc3_pkg::PixW-1:0] pix;

  logic                      s1_valid_q, s1_fwd_q, s1_emit_q, s1_last_q, s1_clr_q;
  logic [AW-1:0]             s1_addr_q;
  logic [rc3_pkg::PixW-1:0]  s1_pix_q, s1_fo_q, s1_fn_q;
  logic [8:0]                s1_mask_q;
  logic [rc3_pkg::PixW-1:0]  ram_o, ram_n, o_eff, n_eff;
  logic                      we, hit;

  // geometry as used, clamped into range
  always_comb begin
    w_ext = 32'(image_width_i);
    h_ext = 32'(image_height_i);
    if (w_ext == 32'd0) w_ext = 32'd1;
    if (w_ext > MAX_WIDTH) w_ext = 32'(MAX_WIDTH);
    if (h_ext == 32'd0) h_ext = 32'd1;
    if (h_ext > MAX_HEIGHT) h_ext = 32'(MAX_HEIGHT);
    w_eff = w_ext[ColW-1:0];
    h_eff = h_ext[RowW-1:0];
  end

  assign accept = in_valid_i && adv_i;
  assign h_s    = $signed({1'b0, h_eff});

  always_comb begin
    wrap0 = col_q >= w_eff;
    c0    = wrap0 ? '0 : col_q;
    r0    = wrap0 ? row_q + RowW'(1) : row_q;
    d0    = drain_q || (r0 >= h_eff);
    take  = accept && ((in_data_i.command == rc3_pkg::CmdDrain) == d0);
    oy    = $signed({1'b0, r0}) - $signed((c0 != '0) ? SW'(1) : SW'(2));
    ox    = (c0 != '0) ? c0 - ColW'(1) : w_eff - ColW'(1);
    c1    = c0 + ColW'(1);
    wrap1 = c1 >= w_eff;
    c1n   = wrap1 ? '0 : c1;
    r1    = wrap1 ? r0 + RowW'(1) : r0;
    d1    = d0 || (r1 >= h_eff);
    neg   = oy < $signed(SW'(0));
    past  = oy >= h_s;
    lastp = d1 && (oy == h_s - $signed(SW'(1))) && (ox == w_eff - ColW'(1));
    emit  = !neg && !past;
    clr   = !neg && (past || lastp);
    row_ok = {oy + $signed(SW'(1)) < h_s, 1'b1, oy >= $signed(SW'(1))};
    col_ok = {ox + ColW'(1) < w_eff, 1'b1, ox >= ColW'(1)};
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask[r*3+c] = row_ok[r] && col_ok[c];
      end
    end
    pix = (in_data_i.command == rc3_pkg::CmdDrain) ? '0 :
          {in_data_i.alpha_in, in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (accept) begin
      if (!take) begin
        col_d = c0; row_d = r0; drain_d = d0;
      end else if (clr) begin
        col_d = '0; row_d = '0; drain_d = 1'b0;
      end else begin
        col_d = c1n; row_d = r1; drain_d = d1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  // write back of the previous column overlaps this read: forward it
  assign we    = adv_i && s1_valid_q;
  assign hit   = s1_valid_q && (s1_addr_q == c0[AW-1:0]);
  assign o_eff = s1_fwd_q ? s1_fo_q : ram_o;
  assign n_eff = s1_fwd_q ? s1_fn_q : ram_n;

  rc3_ram #(.Width(rc3_pkg::PixW), .Depth(MAX_WIDTH)) u_ram_older (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_addr_q),
    .wdata_i(n_eff),
    .re_i   (take),
    .raddr_i(c0[AW-1:0]),
    .rdata_o(ram_o)
  );

  rc3_ram #(.Width(rc3_pkg::PixW), .Depth(MAX_WIDTH)) u_ram_newer (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_pix_q),
    .re_i   (take),
    .raddr_i(c0[AW-1:0]),
    .rdata_o(ram_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= take;
      if (take) s1_fwd_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_addr_q <= c0[AW-1:0];
      s1_pix_q  <= pix;
      s1_mask_q <= mask;
      s1_emit_q <= emit;
      s1_last_q <= emit && lastp;
      s1_clr_q  <= clr;
      s1_fo_q   <= n_eff;
      s1_fn_q   <= s1_pix_q;
    end
  end

  always_comb begin
    beat_o.valid = s1_valid_q;
    beat_o.older = o_eff;
    beat_o.newer = n_eff;
    beat_o.pixel = s1_pix_q;
    beat_o.mask  = s1_mask_q;
    beat_o.emit  = s1_emit_q;
    beat_o.last  = s1_last_q;
    beat_o.clear = s1_clr_q;
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < ColW'(MAX_WIDTH)) else $error("column counter out of range");
  a_fwd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q && s1_valid_q |-> $past(s1_valid_q))
    else $error("forward without an earlier column");
  a_no_write_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |-> !we) else $error("row memory written during a stall");

endmodule

FILE: rtl/rc3_mac.sv
// rc3_mac: 3x3 window, per-tap products, sum, clamp and the output register
// depends on rc3_pkg
module rc3_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  rc3_pkg::col_beat_t  beat_i,
  input  rc3_pkg::kernel_t    kernel_i,
  output logic                out_valid_o,
  output rc3_pkg::pix_out_t   out_data_o
);

  logic [2:0][2:0][rc3_pkg::PixW-1:0] win_q, base;
  logic        s2_valid_q, s2_emit_q, s2_last_q, s2_clr_q;
  logic [8:0]  s2_mask_q;
  logic        s3_valid_q, s3_last_q;
  logic signed [rc3_pkg::ProdW-1:0] prod_d [4][9];
  logic signed [rc3_pkg::ProdW-1:0] prod_q [4][9];
  logic signed [rc3_pkg::SumW-1:0]  sum [4];
  logic [3:0][7:0] clamp;
  logic        out_valid_q;
  rc3_pkg::pix_out_t out_q;

  assign base = (s2_valid_q && s2_clr_q) ? '0 : win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (adv_i) begin
      if (beat_i.valid) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= base[r][1];
          win_q[r][1] <= base[r][2];
        end
        win_q[0][2] <= beat_i.older;
        win_q[1][2] <= beat_i.newer;
        win_q[2][2] <= beat_i.pixel;
      end else begin
        win_q <= base;
      end
    end
  end

  // channel 0 is alpha in the top byte
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      for (int t = 0; t < 9; t++) begin
        prod_d[ch][t] = s2_mask_q[t] ?
          rc3_pkg::ProdW'($signed(kernel_i[t/3][(t%3)*8 +: 8]) *
                          $signed({1'b0, win_q[t/3][t%3][24-8*ch +: 8]})) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q  <= beat_i.valid;
      s3_valid_q  <= s2_valid_q && s2_emit_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_emit_q <= beat_i.emit;
      s2_last_q <= beat_i.last;
      s2_clr_q  <= beat_i.clear;
      s2_mask_q <= beat_i.mask;
      prod_q    <= prod_d;
      s3_last_q <= s2_last_q;
      out_q     <= {clamp, s3_last_q};
    end
  end

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      sum[ch] = '0;
      for (int t = 0; t < 9; t++) begin
        sum[ch] = sum[ch] + rc3_pkg::SumW'(prod_q[ch][t]);
      end
      if (sum[ch] < 0) clamp[3-ch] = 8'd0;
      else if (sum[ch] > 255) clamp[3-ch] = 8'd255;
      else clamp[3-ch] = sum[ch][7:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_valid_q)) else $error("result without a source");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(win_q)) else $error("window moved during a stall");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && s2_valid_q && s2_clr_q && !beat_i.valid |=> win_q == '0)
    else $error("window not cleared at frame end");

endmodule

FILE: rtl/rgba_conv3x3_filter.sv
// rgba_conv3x3_filter: top level of the four-channel 3x3 convolution filter
// depends on rc3_pkg, rc3_line (with rc3_ram) and rc3_mac
//
//   port group   direction  handshake          beat
//   in_*         input      valid / stall      rc3_pkg::pix_in_t (pixel or drain)
//   out_*        output     valid / stall      rc3_pkg::pix_out_t (filtered pixel)
//   cfg_*        input      write enable only  register index and 24-bit data
//
// one beat per clock unless the output stalls; results pass the s1, s2, s3 and output registers
// the row memories are read ahead of their write back, a same-column overlap
//   (one-pixel rows, or a frame start right after a frame end) is forwarded so no beat waits
// reset clears counters, window and valid bits; row memory contents are left as is
// the whole pipeline holds only when a result sits in the output register and is stalled
module rgba_conv3x3_filter #(
  parameter int unsigned MAX_WIDTH  = rc3_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = rc3_pkg::MaxHeightDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rc3_pkg::pix_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rc3_pkg::pix_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [rc3_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rc3_pkg::KernW-1:0]    cfg_data_i
);

  logic [rc3_pkg::ImgWW-1:0] width_q;
  logic [rc3_pkg::ImgHW-1:0] height_q;
  rc3_pkg::kernel_t          kern_q;
  logic                      adv;
  rc3_pkg::col_beat_t        beat;

  // configuration registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= rc3_pkg::WidthRst;
      height_q  <= rc3_pkg::HeightRst;
      kern_q[0] <= rc3_pkg::KernTopRst;
      kern_q[1] <= rc3_pkg::KernMidRst;
      kern_q[2] <= rc3_pkg::KernBotRst;
    end else if (cfg_we_i) begin
      case (rc3_pkg::cfg_idx_e'(cfg_idx_i))
        rc3_pkg::CFG_WIDTH:    width_q   <= cfg_data_i[rc3_pkg::ImgWW-1:0];
        rc3_pkg::CFG_HEIGHT:   height_q  <= cfg_data_i[rc3_pkg::ImgHW-1:0];
        rc3_pkg::CFG_KERN_TOP: kern_q[0] <= cfg_data_i;
        rc3_pkg::CFG_KERN_MID: kern_q[1] <= cfg_data_i;
        rc3_pkg::CFG_KERN_BOT: kern_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: every stage moves unless the output beat is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  rc3_line #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_line (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .image_width_i (width_q),
    .image_height_i(height_q),
    .beat_o        (beat)
  );

  rc3_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .beat_i     (beat),
    .kernel_i   (kern_q),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

FILE: verif/testbench.sv
// testbench: self-checking bench for the rgba 3x3 convolution filter
// depends on rc3_pkg and the rgba_conv3x3_filter rtl; predicts every output beat
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rc3_pkg::*;

  localparam int MaxW = 2048;
  localparam int MaxH = 4096;
  localparam int StallLimit = 20000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pix_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pix_out_t out_data;
  logic     cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [KernW-1:0]   cfg_data;

  rgba_conv3x3_filter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // clock, 20 ns period
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block's registers and frame state
  logic [ImgWW-1:0] shd_width;
  logic [ImgHW-1:0] shd_height;
  logic [KernW-1:0] shd_kern [3];
  logic [31:0] line_older [MaxW];
  logic [31:0] line_newer [MaxW];
  logic [31:0] win [9];
  int unsigned col_cnt, row_cnt;
  bit draining;

  pix_out_t  expected_pixels [$];
  pix_in_t   pending_beats [$];
  int        errors;
  bit        quiet;         // no idling in the last part of the run
  bit        hold_rx;       // long receiver hold-off request
  int        send_gap, recv_gap;

  task automatic report(input string what, input pix_out_t got, input pix_out_t exp);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endtask

  function automatic int signed coef_of(input logic [KernW-1:0] kr, input int c);
    logic signed [7:0] v;
    v = kr[8*c +: 8];
    return int'(v);
  endfunction

  function automatic void clear_frame();
    col_cnt = 0;
    row_cnt = 0;
    draining = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
  endfunction

  // advance the shadow filter by one accepted beat, queue any output pixel
  function automatic void filter_step(input pix_in_t b);
    int w, h, oy, ox, ty, tx, s;
    logic [31:0] px, o, n;
    logic [31:0] rows [3];
    pix_out_t r;
    bit last;
    w = int'(shd_width);
    h = int'(shd_height);
    if (w < 1) w = 1;
    if (w > MaxW) w = MaxW;
    if (h < 1) h = 1;
    if (h > MaxH) h = MaxH;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (!draining && row_cnt >= h) draining = 1;
    if (b.command == CmdPixel && draining) return;
    if (b.command == CmdDrain && !draining) return;
    px = (b.command == CmdPixel) ? {b.alpha_in, b.red_in, b.green_in, b.blue_in} : '0;
    o = line_older[col_cnt];
    n = line_newer[col_cnt];
    line_older[col_cnt] = n;
    line_newer[col_cnt] = px;
    rows[0] = o;
    rows[1] = n;
    rows[2] = px;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
      win[k*3+2] = rows[k];
    end
    if (col_cnt >= 1) begin
      oy = row_cnt - 1;
      ox = col_cnt - 1;
    end else begin
      oy = row_cnt - 2;
      ox = w - 1;
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (!draining && row_cnt >= h) draining = 1;
    if (oy < 0) return;
    if (oy >= h) begin
      clear_frame();
      return;
    end
    last = draining && oy == h - 1 && ox == w - 1;
    for (int ch = 0; ch < 4; ch++) begin
      s = 0;
      for (int k = 0; k < 3; k++) begin
        ty = oy + k - 1;
        if (ty < 0 || ty >= h) continue;
        for (int c = 0; c < 3; c++) begin
          tx = ox + c - 1;
          if (tx < 0 || tx >= w) continue;
          s += coef_of(shd_kern[k], c) * int'(win[k*3+c][24-8*ch +: 8]);
        end
      end
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      case (ch)
        0: r.alpha_out = s[7:0];
        1: r.red_out   = s[7:0];
        2: r.green_out = s[7:0];
        default: r.blue_out = s[7:0];
      endcase
    end
    r.frame_last = last;
    expected_pixels.push_back(r);
    if (last) clear_frame();
  endfunction

  // driver: offers the head of the pending queue, bursts of idling between beats
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        filter_step(in_data);
        void'(pending_beats.pop_front());
      end
      if (in_valid && in_stall) begin
        // payload held while stalled
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_beats[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compares output beats and drives the receiver's stall
  always @(posedge clk or negedge rst_n) begin
    pix_out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected beat", out_data, '0);
        end else begin
          e = expected_pixels.pop_front();
          if (out_data.alpha_out !== e.alpha_out) report("alpha", out_data, e);
          if (out_data.red_out !== e.red_out) report("red", out_data, e);
          if (out_data.green_out !== e.green_out) report("green", out_data, e);
          if (out_data.blue_out !== e.blue_out) report("blue", out_data, e);
          if (out_data.frame_last !== e.frame_last) report("frame_last", out_data, e);
        end
      end
      if (hold_rx) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        recv_gap  <= $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted beat and without a receiver hold
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_rx) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic cfg_write(input cfg_idx_e idx, input logic [KernW-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH:    shd_width  = val[ImgWW-1:0];
      CFG_HEIGHT:   shd_height = val[ImgHW-1:0];
      CFG_KERN_TOP: shd_kern[0] = val;
      CFG_KERN_MID: shd_kern[1] = val;
      default:      shd_kern[2] = val;
    endcase
  endtask

  // wait until the block is empty, then let the pipeline settle
  task automatic wait_idle();
    while (pending_beats.size() > 0 || expected_pixels.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p = pix_in_t'({1'b0, $urandom});
    p.command = CmdPixel;
    return p;
  endfunction

  // one frame: pixels then drain beats, some noise mixed in when noisy is set
  task automatic queue_frame(input int w, input int h, input bit noisy);
    pix_in_t p;
    int wc, hc;
    wc = (w < 1) ? 1 : w;
    hc = (h < 1) ? 1 : h;
    for (int i = 0; i < wc * hc; i++) begin
      if (noisy && $urandom_range(0, 30) == 0) begin
        p = pix_in_t'({1'b0, $urandom});
        p.command = CmdDrain;   // ignored outside the drain
        pending_beats.push_back(p);
      end
      pending_beats.push_back(rand_pixel());
    end
    for (int i = 0; i < wc + 1; i++) begin
      if (noisy && $urandom_range(0, 10) == 0) pending_beats.push_back(rand_pixel());
      p = pix_in_t'({1'b0, $urandom});
      p.command = CmdDrain;
      pending_beats.push_back(p);
    end
  endtask

  task automatic rand_kernel();
    cfg_write(CFG_KERN_TOP, KernW'($urandom));
    cfg_write(CFG_KERN_MID, KernW'($urandom));
    cfg_write(CFG_KERN_BOT, KernW'($urandom));
  endtask

  initial begin
    pix_in_t p;
    int sent, w, h;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_WIDTH;
    cfg_data = '0;
    errors = 0;
    quiet = 0;
    hold_rx = 0;
    idle_cycles = 0;
    shd_width = WidthRst;
    shd_height = HeightRst;
    shd_kern[0] = KernTopRst;
    shd_kern[1] = KernMidRst;
    shd_kern[2] = KernBotRst;
    for (int i = 0; i < MaxW; i++) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    clear_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset kernel (0 1 0 / 1 -8 1 / 0 1 0) on a 4x3 frame with extreme pixels
    cfg_write(CFG_WIDTH, KernW'(4));
    cfg_write(CFG_HEIGHT, KernW'(3));
    for (int i = 0; i < 12; i++) begin
      p = (i % 2) ? '0 : '1;
      p.command = CmdPixel;
      pending_beats.push_back(p);
    end
    p = '1;
    p.command = CmdDrain;
    for (int i = 0; i < 5; i++) pending_beats.push_back(p);
    p = '1;
    p.command = CmdDrain;
    pending_beats.push_back(p);   // drain outside drain phase, ignored
    wait_idle();

    // one-pixel frame with extreme kernels, then height of one
    cfg_write(CFG_KERN_TOP, 24'h7f7f7f);
    cfg_write(CFG_KERN_MID, 24'h808080);
    cfg_write(CFG_KERN_BOT, 24'hffffff);
    cfg_write(CFG_WIDTH, KernW'(1));
    cfg_write(CFG_HEIGHT, KernW'(1));
    queue_frame(1, 1, 0);
    wait_idle();
    cfg_write(CFG_WIDTH, KernW'(3));
    queue_frame(3, 1, 0);
    wait_idle();

    // receiver holds off while the sender keeps offering
    cfg_write(CFG_WIDTH, KernW'(5));
    cfg_write(CFG_HEIGHT, KernW'(4));
    rand_kernel();
    queue_frame(5, 4, 0);
    hold_rx = 1;
    repeat (200) @(posedge clk);
    hold_rx = 0;
    wait_idle();

    // oversized width is clamped, then a narrower width cuts the row short
    cfg_write(CFG_WIDTH, KernW'(12'hfff));
    cfg_write(CFG_HEIGHT, KernW'(2));
    for (int i = 0; i < 5; i++) pending_beats.push_back(rand_pixel());
    wait_idle();
    cfg_write(CFG_WIDTH, KernW'(3));
    queue_frame(3, 1, 0);
    wait_idle();
    cfg_write(CFG_WIDTH, KernW'(0));
    cfg_write(CFG_HEIGHT, KernW'(13'h1fff));
    cfg_write(CFG_HEIGHT, KernW'(2));
    queue_frame(1, 2, 0);
    wait_idle();

    // random frames, small geometries
    sent = 0;
    while (sent < 1000) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 8);
      cfg_write(CFG_WIDTH, KernW'(w));
      cfg_write(CFG_HEIGHT, KernW'(h));
      if ($urandom_range(0, 1)) rand_kernel();
      if (sent > 900) quiet = 1;
      queue_frame(w, h, 1);
      sent += w * h + w + 1;
      if ($urandom_range(0, 3) == 0) begin
        // wait until at most half the frame's pixels plus one beat are pending
        while (pending_beats.size() > (w * h) / 2 + 1) @(posedge clk);
        wait (pending_beats.size() <= 1 && expected_pixels.size() == 0 || 1);
      end
      wait_idle();
    end
    // mid-frame geometry change: part of a 4x4 frame, then a 2x2 frame without noise
    cfg_write(CFG_WIDTH, KernW'(4));
    cfg_write(CFG_HEIGHT, KernW'(4));
    for (int i = 0; i < 6; i++) pending_beats.push_back(rand_pixel());
    wait_idle();
    cfg_write(CFG_WIDTH, KernW'(2));
    cfg_write(CFG_HEIGHT, KernW'(2));
    queue_frame(2, 2, 0);
    wait_idle();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
